FILE: rtl/lcgrr_pkg.sv
// Package with shared constants and types for the bounded LCG random number core.
`timescale 1ns / 1ps

package lcgrr_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned DrawW = 15;
	localparam int unsigned SpanW = DrawW + 1;
	localparam int unsigned AddrW = 3;
	localparam int unsigned CntW  = $clog2(DrawW + 1);

	localparam logic [WordW-1:0] LcgMul    = 32'd1103515245;
	localparam logic [WordW-1:0] LcgAdd    = 32'd12345;
	localparam logic [WordW-1:0] SeedReset = 32'd1;

	// Draw position inside the generator state: bits 30..16.
	localparam int unsigned DrawLsb = 16;

	// Word index of the seed register (byte address divided by four).
	localparam logic SeedIdx = 1'b0;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/lcgrr_lcg.sv
// Generator state, seed register and the multiply-add update of the LCG.
`timescale 1ns / 1ps

module lcgrr_lcg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          seed_we,
	input  logic [lcgrr_pkg::WordW-1:0]   seed_wdata,
	input  logic                          advance,
	output logic [lcgrr_pkg::WordW-1:0]   seed,
	output logic [lcgrr_pkg::DrawW-1:0]   draw
);

	logic [lcgrr_pkg::WordW-1:0] seed_q;
	logic [lcgrr_pkg::WordW-1:0] state_q;
	logic [lcgrr_pkg::WordW-1:0] state_next;

	// Only the low word of the product is kept, which is the wrap modulo 2^32.
	assign state_next = lcgrr_pkg::WordW'(state_q * lcgrr_pkg::LcgMul) + lcgrr_pkg::LcgAdd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= lcgrr_pkg::SeedReset;
			state_q <= lcgrr_pkg::SeedReset;
		end else if (seed_we) begin
			seed_q  <= seed_wdata;
			state_q <= seed_wdata;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	assign seed = seed_q;
	assign draw = state_q[lcgrr_pkg::DrawLsb +: lcgrr_pkg::DrawW];

endmodule

FILE: rtl/lcgrr_rem.sv
// Restoring remainder unit: one dividend bit per cycle, one shared subtract and compare.
`timescale 1ns / 1ps

module lcgrr_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lcgrr_pkg::DrawW-1:0]   dividend,
	input  logic [lcgrr_pkg::SpanW-1:0]   divisor,
	output logic [lcgrr_pkg::SpanW-1:0]   remainder,
	output lcgrr_pkg::div_stat_t          stat
);

	logic [lcgrr_pkg::SpanW-1:0] rem_q;
	logic [lcgrr_pkg::DrawW-1:0] dvd_q;
	logic [lcgrr_pkg::CntW-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [lcgrr_pkg::SpanW-1:0] trial;
	logic                        fits;

	// Bring down the next dividend bit, then subtract when the divisor fits.
	assign trial = {rem_q[lcgrr_pkg::SpanW-2:0], dvd_q[lcgrr_pkg::DrawW-1]};
	assign fits  = (trial >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lcgrr_pkg::CntW'(lcgrr_pkg::DrawW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lcgrr_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - divisor) : trial;
			dvd_q <= {dvd_q[lcgrr_pkg::DrawW-2:0], 1'b0};
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/lcg_random_in_range_core.sv
// Top level: bounded random integers from the 15-bit LCG, with APB seed port.
// Sequence: an accepted request passes the state update, divider load, the bit-serial
// remainder unit, the done handoff and the finish step before its result is registered.
// The next request is taken as soon as the current result sits in the output register;
// while the result side stalls, the finish step holds and no new request is taken.
// Reset: arst_n clears the sequencer and the output valid, and loads seed and state with 1.
`timescale 1ns / 1ps

module lcg_random_in_range_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB-style configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcgrr_pkg::AddrW-1:0]   paddr,
	input  logic [lcgrr_pkg::WordW-1:0]   pwdata,
	output logic [lcgrr_pkg::WordW-1:0]   prdata,
	output logic                          pready,
	// Request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic signed [31:0]            range_low,
	input  logic signed [31:0]            range_high,
	// Result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic signed [31:0]            value,
	output logic                          range_error
);

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ADV    = 5'b00010,
		ST_LOAD   = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} seq_state_t;

	seq_state_t state_q;
	seq_state_t state_next;

	logic                          req_take;
	logic                          seed_we;
	logic [lcgrr_pkg::WordW-1:0]   seed;
	logic [lcgrr_pkg::DrawW-1:0]   draw;
	logic [lcgrr_pkg::SpanW-1:0]   remainder;
	lcgrr_pkg::div_stat_t          div_stat;

	// Request data captured at acceptance.
	logic signed [32:0]            diff;
	logic [lcgrr_pkg::WordW-1:0]   low_q;
	logic [lcgrr_pkg::SpanW-1:0]   span_q;
	logic                          err_q;
	logic                          wide_q;

	// Output register.
	logic                          rsp_valid_q;
	logic [lcgrr_pkg::WordW-1:0]   value_q;
	logic                          range_error_q;
	logic                          out_free;
	logic [lcgrr_pkg::SpanW-1:0]   offset;
	logic [lcgrr_pkg::WordW-1:0]   result;

	// The configuration port never waits. A write hits the seed when the word index matches;
	// the low byte-lane bits of the address are not decoded.
	assign pready  = 1'b1;
	assign seed_we = psel && penable && pwrite && (paddr[2] == lcgrr_pkg::SeedIdx);
	assign prdata  = (paddr[2] == lcgrr_pkg::SeedIdx) ? seed : '0;

	// The core works on one transaction at a time and takes a new one only from idle.
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;

	// high - low is formed at 33 bits so that it never wraps. A negative difference means
	// an empty range. A difference of 32768 or more makes the span larger than any draw,
	// so the draw passes through the modulo unchanged. Otherwise the span fits 16 bits.
	assign diff = 33'(range_high) - 33'(range_low);

	always_ff @(posedge clk) begin
		if (req_take) begin
			low_q  <= range_low;
			err_q  <= diff[32];
			wide_q <= !diff[32] && (|diff[31:lcgrr_pkg::DrawW]);
			span_q <= diff[lcgrr_pkg::SpanW-1:0] + 1'b1;
		end
	end

	lcgrr_lcg u_lcg (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (pwdata),
		.advance    (state_q == ST_ADV),
		.seed       (seed),
		.draw       (draw)
	);

	// The divider is loaded from the freshly advanced state in the cycle after the update.
	lcgrr_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_LOAD),
		.dividend  (draw),
		.divisor   (span_q),
		.remainder (remainder),
		.stat      (div_stat)
	);

	// The result register may be reloaded when it is empty or being taken this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:   if (req_take) state_next = ST_ADV;
			ST_ADV:    state_next = ST_LOAD;
			ST_LOAD:   state_next = ST_DIV;
			ST_DIV:    if (div_stat.done) state_next = ST_FINISH;
			ST_FINISH: if (out_free) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Final value: draw mod span plus the lower bound, wrapping at 32 bits. The true
	// result always lies inside the requested range, so the wrap never changes it.
	assign offset = wide_q ? {1'b0, draw} : remainder;
	assign result = low_q + {{(lcgrr_pkg::WordW - lcgrr_pkg::SpanW){1'b0}}, offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			value_q       <= err_q ? '0 : result;
			range_error_q <= err_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign value       = value_q;
	assign range_error = range_error_q;

endmodule
